### rtl/core/jft_pkg.sv
// ----------------------------------------------------------------------------
// jft_pkg
// Shared types, codes and helper functions for the flat JSON object
// tokenizer: parse states, result kinds, error codes and state records.
// ----------------------------------------------------------------------------
package jft_pkg;

    // Characters that drive the parser.
    localparam logic [7:0] CH_LBRACE = 8'h7B;  // open brace
    localparam logic [7:0] CH_RBRACE = 8'h7D;  // close brace
    localparam logic [7:0] CH_QUOTE  = 8'h22;  // double quote
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_EQUALS = 8'h3D;  // base64 padding
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [15:0] VALUE_COUNT_MAX = 16'hFFFF;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_FIELD_LIMIT     = 2'd0,
        REG_VALUE_LIMIT     = 2'd1,
        REG_DATA_FIELD_NAME = 2'd2,
        REG_UNUSED          = 2'd3
    } cfg_index_t;

    localparam logic [7:0]  FIELD_LIMIT_RESET     = 8'd32;
    localparam logic [11:0] VALUE_LIMIT_RESET     = 12'd256;
    localparam logic [31:0] DATA_FIELD_NAME_RESET = 32'h64617461;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_EXP_FIELD = 3'd1,
        ST_IN_FIELD  = 3'd2,
        ST_EXP_COLON = 3'd3,
        ST_EXP_VALUE = 3'd4,
        ST_IN_STRING = 3'd5,
        ST_IN_NUMBER = 3'd6,
        ST_EXP_COMMA = 3'd7
    } parse_state_t;

    typedef enum logic [2:0] {
        KIND_STRUCT     = 3'd0,
        KIND_NAME_CHAR  = 3'd1,
        KIND_VALUE_CHAR = 3'd2,
        KIND_FIELD_END  = 3'd3,
        KIND_OBJ_END    = 3'd4,
        KIND_ERROR      = 3'd5,
        KIND_DISCARD    = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_SYNTAX    = 2'd1,
        ERR_NAME_LONG = 2'd2,
        ERR_VALUE_LONG = 2'd3
    } err_code_t;

    typedef struct packed {
        logic [7:0]  field_limit;
        logic [11:0] value_limit;
        logic [31:0] data_field_name;
    } jft_cfg_t;

    typedef struct packed {
        parse_state_t parse_state;
        logic [7:0]   name_count;
        logic [15:0]  value_count;
        logic [31:0]  name_head;
        logic [15:0]  last_two_bytes;
        logic         discarding;
    } jft_state_t;

    localparam jft_state_t STATE_RESET = '{
        parse_state:    ST_IDLE,
        name_count:     8'd0,
        value_count:    16'd0,
        name_head:      32'd0,
        last_two_bytes: 16'd0,
        discarding:     1'b0
    };

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic        is_string;
        logic        is_data;
        logic [7:0]  name_length;
        logic [15:0] value_length;
        logic [15:0] decoded_size;
        logic        object_done;
        err_code_t   error_code;
    } jft_result_t;

    function automatic logic is_decimal_char(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    // True when the name seen so far is a prefix of the data field name.
    // An empty name matches; a name of more than four characters never does.
    function automatic logic prefix_match(input logic [7:0]  name_count,
                                          input logic [31:0] name_head,
                                          input logic [31:0] data_name);
        logic m;
        case (name_count)
            8'd0:    m = 1'b1;
            8'd1:    m = (name_head[31:24] == data_name[31:24]);
            8'd2:    m = (name_head[31:16] == data_name[31:16]);
            8'd3:    m = (name_head[31:8] == data_name[31:8]);
            8'd4:    m = (name_head == data_name);
            default: m = 1'b0;
        endcase
        return m;
    endfunction

endpackage

### rtl/core/jft_step.sv
// ----------------------------------------------------------------------------
// jft_step
// Next-state and result logic for one byte: parse state transitions,
// length checks, name prefix tracking and base64 size derivation.
// ----------------------------------------------------------------------------
module jft_step (
    input  jft_pkg::jft_cfg_t    cfg,
    input  jft_pkg::jft_state_t  cur,
    input  logic [7:0]           in_byte,
    input  logic                 chunk_start,
    output jft_pkg::jft_state_t  nxt,
    output jft_pkg::jft_result_t res
);
    import jft_pkg::*;

    logic        match_cur;
    logic [13:0] quarter;
    logic [15:0] dec_base;
    logic [15:0] dec_one;
    logic [15:0] dec_size;
    logic        name_full;
    logic        value_full;
    logic [15:0] last_two_shift;
    err_code_t   err;

    assign match_cur  = prefix_match(cur.name_count, cur.name_head, cfg.data_field_name);
    assign name_full  = (cur.name_count >= cfg.field_limit);
    assign value_full = (cur.value_count >= {4'd0, cfg.value_limit});
    assign last_two_shift = {cur.last_two_bytes[7:0], in_byte};

    // Decoded size is three bytes per four characters, less the padding.
    assign quarter  = cur.value_count[15:2];
    assign dec_base = {1'b0, quarter, 1'b0} + {2'b00, quarter};

    always_comb
    begin
        dec_one  = dec_base;
        dec_size = dec_base;
        if (cur.value_count > 16'd2)
        begin
            if (cur.last_two_bytes[7:0] == CH_EQUALS && dec_base != 16'd0)
                dec_one = dec_base - 16'd1;
            dec_size = dec_one;
            if (cur.last_two_bytes[15:8] == CH_EQUALS && dec_one != 16'd0)
                dec_size = dec_one - 16'd1;
        end
    end

    always_comb
    begin
        nxt = cur;
        err = ERR_NONE;
        res.kind         = KIND_STRUCT;
        res.out_byte     = 8'd0;
        res.is_string    = 1'b0;
        res.decoded_size = 16'd0;
        res.object_done  = 1'b0;

        if (chunk_start)
            nxt.discarding = 1'b0;

        if (nxt.discarding)
        begin
            res.kind = KIND_DISCARD;
        end
        else
        begin
            case (cur.parse_state)
                ST_IDLE:
                begin
                    if (in_byte != CH_LBRACE)
                        err = ERR_SYNTAX;
                    else
                        nxt.parse_state = ST_EXP_FIELD;
                end
                ST_EXP_FIELD:
                begin
                    if (in_byte != CH_QUOTE)
                        err = ERR_SYNTAX;
                    else
                    begin
                        nxt.parse_state = ST_IN_FIELD;
                        nxt.name_count  = 8'd0;
                        nxt.name_head   = 32'd0;
                    end
                end
                ST_IN_FIELD:
                begin
                    if (in_byte == CH_QUOTE)
                        nxt.parse_state = ST_EXP_COLON;
                    else if (name_full)
                        err = ERR_NAME_LONG;
                    else
                    begin
                        case (cur.name_count)
                            8'd0:    nxt.name_head[31:24] = in_byte;
                            8'd1:    nxt.name_head[23:16] = in_byte;
                            8'd2:    nxt.name_head[15:8]  = in_byte;
                            8'd3:    nxt.name_head[7:0]   = in_byte;
                            default: nxt.name_head = cur.name_head;
                        endcase
                        nxt.name_count = cur.name_count + 8'd1;
                        res.kind       = KIND_NAME_CHAR;
                        res.out_byte   = in_byte;
                    end
                end
                ST_EXP_COLON:
                begin
                    if (in_byte != CH_COLON)
                        err = ERR_SYNTAX;
                    else
                    begin
                        nxt.parse_state = ST_EXP_VALUE;
                        nxt.value_count = 16'd0;
                    end
                end
                ST_EXP_VALUE:
                begin
                    if (in_byte == CH_QUOTE)
                        nxt.parse_state = ST_IN_STRING;
                    else if (!is_decimal_char(in_byte))
                        err = ERR_SYNTAX;
                    else
                    begin
                        // The first digit is stored without a limit check.
                        nxt.parse_state = ST_IN_NUMBER;
                        if (cur.value_count != VALUE_COUNT_MAX)
                            nxt.value_count = cur.value_count + 16'd1;
                        res.kind     = KIND_VALUE_CHAR;
                        res.out_byte = in_byte;
                    end
                end
                ST_IN_STRING:
                begin
                    if (in_byte == CH_QUOTE)
                    begin
                        res.kind        = KIND_FIELD_END;
                        res.is_string   = 1'b1;
                        if (match_cur)
                            res.decoded_size = dec_size;
                        nxt.parse_state = ST_EXP_COMMA;
                    end
                    else if (value_full)
                    begin
                        // Only the data field may overflow: bytes are counted only.
                        if (match_cur && cur.name_count == 8'd4)
                        begin
                            if (cur.value_count != VALUE_COUNT_MAX)
                                nxt.value_count = cur.value_count + 16'd1;
                            nxt.last_two_bytes = last_two_shift;
                        end
                        else
                            err = ERR_VALUE_LONG;
                    end
                    else
                    begin
                        nxt.value_count    = cur.value_count + 16'd1;
                        nxt.last_two_bytes = last_two_shift;
                        res.kind      = KIND_VALUE_CHAR;
                        res.out_byte  = in_byte;
                        res.is_string = 1'b1;
                    end
                end
                ST_IN_NUMBER:
                begin
                    if (in_byte == CH_RBRACE)
                    begin
                        res.kind        = KIND_FIELD_END;
                        res.object_done = 1'b1;
                        nxt.parse_state = ST_IDLE;
                        nxt.discarding  = 1'b1;
                    end
                    else if (in_byte == CH_COMMA)
                    begin
                        res.kind        = KIND_FIELD_END;
                        nxt.parse_state = ST_EXP_FIELD;
                    end
                    else if (!is_decimal_char(in_byte))
                        err = ERR_SYNTAX;
                    else if (value_full)
                        err = ERR_VALUE_LONG;
                    else
                    begin
                        nxt.value_count = cur.value_count + 16'd1;
                        res.kind     = KIND_VALUE_CHAR;
                        res.out_byte = in_byte;
                    end
                end
                ST_EXP_COMMA:
                begin
                    if (in_byte == CH_RBRACE)
                    begin
                        res.kind        = KIND_OBJ_END;
                        nxt.parse_state = ST_IDLE;
                        nxt.discarding  = 1'b1;
                    end
                    else if (in_byte != CH_COMMA)
                        err = ERR_SYNTAX;
                    else
                        nxt.parse_state = ST_EXP_FIELD;
                end
                default:
                begin
                    err = ERR_SYNTAX;
                end
            endcase

            // An error leaves the parse state alone and drops the rest of the chunk.
            if (err != ERR_NONE)
            begin
                res.kind       = KIND_ERROR;
                res.out_byte   = 8'd0;
                res.is_string  = 1'b0;
                nxt.discarding = 1'b1;
            end
        end

        res.error_code   = err;
        res.is_data      = prefix_match(nxt.name_count, nxt.name_head, cfg.data_field_name);
        res.name_length  = nxt.name_count;
        res.value_length = nxt.value_count;
    end

endmodule

### rtl/core/flat_json_object_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// flat_json_object_tokenizer_unit
// Byte-at-a-time tokenizer for flat JSON objects, one result item per byte.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                               Handshake
//  -------   ---------  ------------------------------------  ------------------
//  s_axis    in         tdata: in_byte, tuser: chunk_start    tvalid / tready
//  m_axis    out        tdata: result fields, tuser: kind      tvalid / tready
//  cfg       in         cfg_index, cfg_data                   cfg_valid/cfg_ready
//
//  Every accepted byte produces exactly one result item, passing through the
//  input register and then the result register. When the output side is not
//  stalled, a new byte can be taken in every cycle; the rate is set by the state
//  update between the two registers, carrying the parse state from byte to byte.
//  A stall on m_axis holds the result register; one more byte may then wait in
//  the input register before s_axis_tready drops.
//  Reset (rst_n low, asynchronous) puts the parser in the idle state, clears
//  all counters and restores the configuration defaults. cfg_ready is always
//  high; configuration writes are expected only while the unit is idle.
//
module flat_json_object_tokenizer_unit (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_axis_tuser,   // [0] chunk_start

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_byte, [8] is_string, [9] is_data, [17:10] name_length,
    // [33:18] value_length, [49:34] decoded_size, [50] object_done,
    // [52:51] error_code, [55:53] zero
    output logic [55:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // [2:0] kind

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import jft_pkg::*;

    // Configuration registers.
    jft_cfg_t    cfg_reg;

    // Input register stage.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;

    // Parser state carried from byte to byte.
    jft_state_t  state_reg;
    jft_state_t  state_next;

    // Result register stage.
    logic        out_valid_reg;
    jft_result_t result_reg;
    jft_result_t result_next;

    logic        advance;
    logic        in_accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.field_limit     <= FIELD_LIMIT_RESET;
            cfg_reg.value_limit     <= VALUE_LIMIT_RESET;
            cfg_reg.data_field_name <= DATA_FIELD_NAME_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                REG_FIELD_LIMIT:     cfg_reg.field_limit     <= cfg_data[7:0];
                REG_VALUE_LIMIT:     cfg_reg.value_limit     <= cfg_data[11:0];
                REG_DATA_FIELD_NAME: cfg_reg.data_field_name <= cfg_data;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The byte in the input register moves on whenever the result register
    // is free or is being emptied in this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser[0];
        end
    end

    jft_step u_step (
        .cfg         (cfg_reg),
        .cur         (state_reg),
        .in_byte     (in_byte_reg),
        .chunk_start (in_start_reg),
        .nxt         (state_next),
        .res         (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (advance)
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = result_reg.kind;
    assign m_axis_tdata  = {3'b000,
                            result_reg.error_code,
                            result_reg.object_done,
                            result_reg.decoded_size,
                            result_reg.value_length,
                            result_reg.name_length,
                            result_reg.is_data,
                            result_reg.is_string,
                            result_reg.out_byte};

`ifndef ASSERT_OFF
    // An error result carries a code, and only an error result does.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == KIND_ERROR) == (m_axis_tdata[52:51] != ERR_NONE)))
        else $error("error kind and error code disagree");

    // After an error or an object end, the parser is in discard mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (result_next.kind == KIND_ERROR || result_next.kind == KIND_OBJ_END
                     || result_next.object_done))
        |=> state_reg.discarding)
        else $error("discard mode not entered");

    // Input backpressure only comes from a stalled, full pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without cause");

    // A closing field end returns the parser to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result_next.object_done) |=> (state_reg.parse_state == ST_IDLE))
        else $error("object close did not return to idle");
`endif

endmodule
